@@ rtl/pds_pkg.sv @@
// Shared types, constants, divider tables and the sequencer program for the divider search.
`timescale 1ns / 1ps

package pds_pkg;

  // Datapath widths of the shared restoring divider.
  localparam int DIV_DW = 36;
  localparam int DIV_VW = 20;
  localparam int DIV_CW = $clog2(DIV_DW);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_DIV  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ODD_EN   = 3'd4;

  // Program step addresses.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CHK_UNIT = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MULP     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_DIVQ     = 5'd3;
  localparam logic [STEP_W-1:0] STEP_WAIT_Q   = 5'd4;
  localparam logic [STEP_W-1:0] STEP_ROUND    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_CHECK    = 5'd6;
  localparam logic [STEP_W-1:0] STEP_NEXT     = 5'd7;
  localparam logic [STEP_W-1:0] STEP_LOOP     = 5'd8;
  localparam logic [STEP_W-1:0] STEP_DIVR     = 5'd9;
  localparam logic [STEP_W-1:0] STEP_WAIT_R   = 5'd10;
  localparam logic [STEP_W-1:0] STEP_MULN     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_DIVP     = 5'd12;
  localparam logic [STEP_W-1:0] STEP_WAIT_P   = 5'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT_OK  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RET_OK   = 5'd15;
  localparam logic [STEP_W-1:0] STEP_FAIL     = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RET_FAIL = 5'd17;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MULP,
    OP_DIVQ,
    OP_ROUND,
    OP_NEXT,
    OP_DIVR,
    OP_MULN,
    OP_DIVP,
    OP_EMIT_OK,
    OP_EMIT_FAIL
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_UNIT_ZERO,
    C_DIV_BUSY,
    C_ACCEPT,
    C_LAST,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Status flags that the datapath hands to the sequencer.
  typedef struct packed {
    logic no_input;
    logic unit_zero;
    logic div_busy;
    logic accept;
    logic last;
    logic out_busy;
  } cond_flags_t;

  // Start request for the shared divider.
  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  // Post divider ratios, largest first.
  function automatic logic [3:0] post_value(input logic [2:0] idx);
    logic [3:0] v;
    case (idx)
      3'd0: v = 4'd12;
      3'd1: v = 4'd8;
      3'd2: v = 4'd6;
      3'd3: v = 4'd5;
      3'd4: v = 4'd4;
      3'd5: v = 4'd3;
      3'd6: v = 4'd2;
      default: v = 4'd1;
    endcase
    return v;
  endfunction

  // Hardware codes of the post dividers in the same order.
  function automatic logic [2:0] post_code(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0: c = 3'h7;
      3'd1: c = 3'h3;
      3'd2: c = 3'h6;
      3'd3: c = 3'h5;
      3'd4: c = 3'h2;
      3'd5: c = 3'h4;
      3'd6: c = 3'h1;
      default: c = 3'h0;
    endcase
    return c;
  endfunction

  // The control program. A jump goes to target when its condition holds.
  function automatic ctrl_word_t prog_word(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:     w = '{OP_LOAD,      C_NO_INPUT,  STEP_IDLE};
      STEP_CHK_UNIT: w = '{OP_NOP,       C_UNIT_ZERO, STEP_FAIL};
      STEP_MULP:     w = '{OP_MULP,      C_NEVER,     STEP_IDLE};
      STEP_DIVQ:     w = '{OP_DIVQ,      C_NEVER,     STEP_IDLE};
      STEP_WAIT_Q:   w = '{OP_NOP,       C_DIV_BUSY,  STEP_WAIT_Q};
      STEP_ROUND:    w = '{OP_ROUND,     C_NEVER,     STEP_IDLE};
      STEP_CHECK:    w = '{OP_NOP,       C_ACCEPT,    STEP_DIVR};
      STEP_NEXT:     w = '{OP_NEXT,      C_LAST,      STEP_FAIL};
      STEP_LOOP:     w = '{OP_NOP,       C_ALWAYS,    STEP_MULP};
      STEP_DIVR:     w = '{OP_DIVR,      C_NEVER,     STEP_IDLE};
      STEP_WAIT_R:   w = '{OP_NOP,       C_DIV_BUSY,  STEP_WAIT_R};
      STEP_MULN:     w = '{OP_MULN,      C_NEVER,     STEP_IDLE};
      STEP_DIVP:     w = '{OP_DIVP,      C_NEVER,     STEP_IDLE};
      STEP_WAIT_P:   w = '{OP_NOP,       C_DIV_BUSY,  STEP_WAIT_P};
      STEP_EMIT_OK:  w = '{OP_EMIT_OK,   C_OUT_BUSY,  STEP_EMIT_OK};
      STEP_RET_OK:   w = '{OP_NOP,       C_ALWAYS,    STEP_IDLE};
      STEP_FAIL:     w = '{OP_EMIT_FAIL, C_OUT_BUSY,  STEP_FAIL};
      STEP_RET_FAIL: w = '{OP_NOP,       C_ALWAYS,    STEP_IDLE};
      default:       w = '{OP_NOP,       C_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/pds_div.sv @@
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module pds_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pds_pkg::div_req_t         req,
  output logic                      busy,
  output logic [pds_pkg::DIV_DW-1:0] quotient,
  output logic [pds_pkg::DIV_VW-1:0] remainder
);
  import pds_pkg::*;

  logic              busy_r, busy_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_VW:0]   rem_sh;
  logic [DIV_VW:0]   diff;
  logic              ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_r, quo_r[DIV_DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_DW-2:0], ge};
      rem_nxt = ge ? diff[DIV_VW-1:0] : rem_sh[DIV_VW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_DW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/pds_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
`timescale 1ns / 1ps

module pds_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pds_pkg::cond_flags_t flags,
  output pds_pkg::op_t         op,
  output logic                 idle
);
  import pds_pkg::*;

  logic [STEP_W-1:0] pc_r, pc_nxt;
  ctrl_word_t        cw;
  logic              take;

  assign cw = prog_word(pc_r);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = flags.no_input;
      C_UNIT_ZERO: take = flags.unit_zero;
      C_DIV_BUSY:  take = flags.div_busy;
      C_ACCEPT:    take = flags.accept;
      C_LAST:      take = flags.last;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b0;
    endcase
    pc_nxt = take ? cw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op   = cw.op;
  assign idle = (pc_r == STEP_IDLE);

endmodule

@@ rtl/pll_divider_search.sv @@
// Top level of the PLL feedback and post divider search.
`timescale 1ns / 1ps

// The block takes a requested output clock frequency on the in_ channel and
// returns one result per request on the out_ channel: status, post divider
// ratio and code, feedback divider and achieved frequency. Both channels use
// valid and stall; a transfer happens on a clock edge with valid high and
// stall low. Configuration registers are written through cfg_we, cfg_index
// and cfg_wdata. The user must write them only while no request is in
// progress; the block itself does not enforce this. Writes to unknown
// indexes are dropped. Requests are handled one at a time. A microcoded
// sequencer runs each post divider trial through a shared one-bit-per-cycle
// divider of 36 steps, and the achieved frequency needs two more divisions.
// The trials stop at the first post divider that fits or after all eight;
// a request whose reference is too low for a solution skips the trials.
// A finished result sits in the output register while the next request is
// taken. When the receiver stalls, the sequencer holds the next result
// until the output register is free. Synchronous reset returns all
// configuration registers to their defaults and empties the block.
module pll_divider_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [27:0]                   in_target_freq,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [3:0]                    out_post_div_value,
  output logic [2:0]                    out_post_div_code,
  output logic [7:0]                    out_feedback_div,
  output logic [34:0]                   out_achieved_freq,
  input  logic                          cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [26:0]                   cfg_wdata
);
  import pds_pkg::*;

  // Configuration registers.
  logic [26:0] ref_freq_r;
  logic [7:0]  ref_div_r;
  logic [7:0]  fb_min_r;
  logic [7:0]  fb_max_r;
  logic        odd_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r <= 27'd14318180;
      ref_div_r  <= 8'd1;
      fb_min_r   <= 8'd0;
      fb_max_r   <= 8'd255;
      odd_en_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_FREQ: ref_freq_r <= cfg_wdata;
        CFG_REF_DIV:  ref_div_r  <= cfg_wdata[7:0];
        CFG_FB_MIN:   fb_min_r   <= cfg_wdata[7:0];
        CFG_FB_MAX:   fb_max_r   <= cfg_wdata[7:0];
        CFG_ODD_EN:   odd_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer and shared divider.
  cond_flags_t       flags;
  op_t               op;
  logic              idle;
  div_req_t          div_req;
  logic              div_busy;
  logic [DIV_DW-1:0] div_quo;
  logic [DIV_VW-1:0] div_rem;

  pds_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op),
    .idle  (idle)
  );

  pds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Datapath registers.
  logic [27:0] fm_r, fm_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] q_r, q_nxt;
  logic [35:0] x_r, x_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        status_r, status_nxt;
  logic [3:0]  pval_r, pval_nxt;
  logic [2:0]  pcode_r, pcode_nxt;
  logic [7:0]  fb_r, fb_nxt;
  logic [34:0] ach_r, ach_nxt;

  logic [19:0] unit;
  logic [18:0] half;
  logic [3:0]  cur_pval;
  logic [2:0]  cur_pcode;
  logic        in_xfer;
  logic        out_busy;
  logic        rnd_up;
  logic [34:0] ach_sat;

  assign unit      = ref_freq_r[26:7];
  assign half      = ref_freq_r[26:8];
  assign cur_pval  = post_value(idx_r);
  assign cur_pcode = post_code(idx_r);
  assign in_stall  = !idle;
  assign in_xfer   = in_valid && !in_stall;
  assign out_busy  = out_valid_r && out_stall;

  // Round the quotient up when the remainder reaches half a unit and the quotient is below the feedback maximum.
  assign rnd_up = (div_quo[31:0] < {24'd0, fb_max_r}) && (div_rem >= {1'b0, half});

  // Achieved frequency with saturation; a zero reference divider gives zero.
  assign ach_sat = (ref_div_r == 8'd0) ? 35'd0 :
                   div_quo[35]          ? {35{1'b1}} : div_quo[34:0];

  // Flags for the sequencer.
  always_comb begin
    flags.no_input  = !in_xfer;
    flags.unit_zero = (unit == 20'd0);
    flags.div_busy  = div_busy;
    flags.accept    = (q_r <= {24'd0, fb_max_r}) && (q_r >= {24'd0, fb_min_r}) &&
                      (odd_en_r || !cur_pcode[2]);
    flags.last      = &idx_r;
    flags.out_busy  = out_busy;
  end

  // Divider operand selection.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = x_r;
    div_req.divisor  = unit;
    case (op)
      OP_DIVQ: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'd0, prod_r};
        div_req.divisor  = unit;
      end
      OP_DIVR: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, ref_freq_r, 1'b0};
        div_req.divisor  = {12'd0, ref_div_r};
      end
      OP_DIVP: begin
        div_req.start    = 1'b1;
        div_req.dividend = x_r;
        div_req.divisor  = {16'd0, cur_pval};
      end
      default: ;
    endcase
  end

  // Datapath actions selected by the control word.
  always_comb begin
    fm_nxt        = fm_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    q_nxt         = q_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    pval_nxt      = pval_r;
    pcode_nxt     = pcode_r;
    fb_nxt        = fb_r;
    ach_nxt       = ach_r;

    // A waiting result leaves once it is transferred.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (op)
      OP_LOAD: begin
        if (in_xfer) begin
          fm_nxt  = 28'(in_target_freq[27:8]) * 28'(ref_div_r);
          idx_nxt = '0;
        end
      end
      OP_MULP:  prod_nxt = 32'(fm_r) * 32'(cur_pval);
      OP_ROUND: q_nxt = div_quo[31:0] + {31'd0, rnd_up};
      OP_NEXT:  idx_nxt = idx_r + 1'b1;
      OP_MULN:  x_nxt = 36'(div_quo[27:0]) * 36'(q_r[7:0]);
      OP_EMIT_OK: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          status_nxt    = 1'b0;
          pval_nxt      = cur_pval;
          pcode_nxt     = cur_pcode;
          fb_nxt        = q_r[7:0];
          ach_nxt       = ach_sat;
        end
      end
      OP_EMIT_FAIL: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          status_nxt    = 1'b1;
          pval_nxt      = '0;
          pcode_nxt     = '0;
          fb_nxt        = '0;
          ach_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    fm_r     <= fm_nxt;
    idx_r    <= idx_nxt;
    prod_r   <= prod_nxt;
    q_r      <= q_nxt;
    x_r      <= x_nxt;
    status_r <= status_nxt;
    pval_r   <= pval_nxt;
    pcode_r  <= pcode_nxt;
    fb_r     <= fb_nxt;
    ach_r    <= ach_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_post_div_value = pval_r;
  assign out_post_div_code  = pcode_r;
  assign out_feedback_div   = fb_r;
  assign out_achieved_freq  = ach_r;

endmodule

@@ test/tb_pll_divider_search.sv @@
// Self-checking testbench for the PLL feedback and post divider search block.
`timescale 1ns / 1ps

module tb_pll_divider_search;
  import pds_pkg::*;

  // Post divider ratios and their hardware codes, largest ratio first.
  localparam logic [31:0] RATIO_TAB   = {4'd12, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
  localparam logic [23:0] CODE_TAB    = {3'h7, 3'h3, 3'h6, 3'h5, 3'h2, 3'h4, 3'h1, 3'h0};
  localparam logic [63:0] FREQ_SAT    = (64'd1 << 35) - 64'd1;
  localparam logic [27:0] PIXEL_CLK   = 28'd25175000;
  localparam int          CYCLE_LIMIT = 6000000;
  localparam int          RAND_PHASES = 15;
  localparam int          PHASE_ITEMS = 123;

  typedef struct packed {
    logic        status;
    logic [3:0]  ratio;
    logic [2:0]  code;
    logic [7:0]  fb_div;
    logic [34:0] freq;
  } pll_settings_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [27:0]          in_target_freq = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_status;
  logic [3:0]           out_post_div_value;
  logic [2:0]           out_post_div_code;
  logic [7:0]           out_feedback_div;
  logic [34:0]          out_achieved_freq;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [26:0]          cfg_wdata = '0;

  // Local copy of the configuration registers, starting at their reset values.
  logic [26:0] ref_freq_q = 27'd14318180;
  logic [7:0]  ref_div_q  = 8'd1;
  logic [7:0]  fb_min_q   = 8'd0;
  logic [7:0]  fb_max_q   = 8'd255;
  logic        odd_en_q   = 1'b0;

  pll_settings_t settings_q[$];
  int            error_count = 0;
  int            result_count = 0;
  int            burst_left = 0;
  int            cycle_count = 0;
  int            stall_mode = 0;
  int            stall_cnt = 0;

  pll_divider_search uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_target_freq     (in_target_freq),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_post_div_value (out_post_div_value),
    .out_post_div_code  (out_post_div_code),
    .out_feedback_div   (out_feedback_div),
    .out_achieved_freq  (out_achieved_freq),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Expected PLL settings for one requested frequency under the current registers.
  function automatic pll_settings_t predict_settings(input logic [27:0] freq);
    logic [63:0]   unit, half, prod, quo, rem, ach, n_sel;
    logic [3:0]    ratio, ratio_sel;
    logic [2:0]    code, code_sel;
    logic          found;
    pll_settings_t res;
    res = '0;
    res.status = 1'b1;
    found = 1'b0;
    n_sel = '0;
    ratio_sel = '0;
    code_sel = '0;
    unit = 64'(ref_freq_q) >> 7;
    half = 64'(ref_freq_q) >> 8;
    // A reference below 128 Hz leaves no unit to divide by, so nothing is found.
    if (unit != 0) begin
      for (int i = 0; i < 8; i++) begin
        ratio = RATIO_TAB[4*(7-i) +: 4];
        code  = CODE_TAB[3*(7-i) +: 3];
        prod  = (64'(freq) >> 8) * 64'(ref_div_q) * 64'(ratio);
        quo   = prod / unit;
        rem   = prod % unit;
        if (quo < 64'(fb_max_q) && rem >= half) quo = quo + 1;
        // Codes with the top bit set are allowed only when odd dividers are enabled.
        if (!found && quo <= 64'(fb_max_q) && quo >= 64'(fb_min_q) &&
            (odd_en_q || !code[2])) begin
          found = 1'b1;
          n_sel = quo;
          ratio_sel = ratio;
          code_sel = code;
        end
      end
    end
    if (found) begin
      ach = '0;
      if (ref_div_q != 0) begin
        ach = ((64'(ref_freq_q) << 1) / 64'(ref_div_q)) * n_sel / 64'(ratio_sel);
        if (ach > FREQ_SAT) ach = FREQ_SAT;
      end
      res.status = 1'b0;
      res.ratio  = ratio_sel;
      res.code   = code_sel;
      res.fb_div = n_sel[7:0];
      res.freq   = ach[34:0];
    end
    return res;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] result %0d: %s got %0h expected %0h", $realtime, result_count,
             what, got, want);
    error_count++;
  endtask

  // One register write; the local copy follows the same index decode.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [26:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REF_FREQ: ref_freq_q = val;
      CFG_REF_DIV:  ref_div_q  = val[7:0];
      CFG_FB_MIN:   fb_min_q   = val[7:0];
      CFG_FB_MAX:   fb_max_q   = val[7:0];
      CFG_ODD_EN:   odd_en_q   = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [26:0] fref, input logic [26:0] rdiv,
                                input logic [26:0] fmin, input logic [26:0] fmax,
                                input logic [26:0] odd);
    write_reg(CFG_REF_FREQ, fref);
    write_reg(CFG_REF_DIV, rdiv);
    write_reg(CFG_FB_MIN, fmin);
    write_reg(CFG_FB_MAX, fmax);
    write_reg(CFG_ODD_EN, odd);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (settings_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sends one request; bursts of random length are separated by random gaps.
  task automatic send_target(input logic [27:0] freq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_target_freq <= freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    settings_q.push_back(predict_settings(freq));
  endtask

  function automatic logic [27:0] random_target();
    logic [27:0] f;
    case ($urandom_range(0, 9))
      0: f = 28'($urandom);
      1: f = 28'($urandom_range(0, 1000000));
      2: f = 28'($urandom_range(0, 255));
      default: f = 28'($urandom_range(1000000, 250000000));
    endcase
    return f;
  endfunction

  // Reset values of every register, with the edges of the input range.
  task automatic test_reset_defaults();
    send_target(28'd0);
    send_target(PIXEL_CLK);
    send_target(28'd250000000);
    send_target(28'hFFFFFFF);
  endtask

  // Odd post dividers allowed.
  task automatic test_odd_dividers();
    wait_drained();
    write_reg(CFG_ODD_EN, 27'd1);
    send_target(PIXEL_CLK);
    send_target(28'd100000000);
    send_target(28'd1000000);
  endtask

  // Windows that are pinned at the top, inverted or pinned at zero.
  task automatic test_feedback_window();
    wait_drained();
    apply_settings(27'd14318180, 27'd1, 27'd255, 27'd255, 27'd0);
    send_target(PIXEL_CLK);
    wait_drained();
    apply_settings(27'd14318180, 27'd1, 27'd100, 27'd50, 27'd1);
    send_target(PIXEL_CLK);
    wait_drained();
    apply_settings(27'd14318180, 27'd1, 27'd0, 27'd0, 27'd1);
    send_target(28'd0);
  endtask

  // References around 128 Hz, where the divisor unit vanishes or is one.
  task automatic test_low_reference();
    logic [26:0] fref_list [4];
    fref_list = '{27'd0, 27'd127, 27'd128, 27'd255};
    for (int i = 0; i < 4; i++) begin
      wait_drained();
      apply_settings(fref_list[i], 27'd1, 27'd0, 27'd255, 27'd1);
      send_target(PIXEL_CLK);
    end
  endtask

  // A reference divider of zero makes every product zero.
  task automatic test_zero_ref_divider();
    wait_drained();
    apply_settings(27'd14318180, 27'd0, 27'd0, 27'd255, 27'd0);
    send_target(PIXEL_CLK);
    send_target(28'd0);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_bad_index();
    wait_drained();
    apply_settings(27'd14318180, 27'd2, 27'd10, 27'd200, 27'd0);
    for (int k = 1; k <= 3; k++) write_reg(CFG_IDX_W'(CFG_ODD_EN + k), 27'($urandom));
    send_target(PIXEL_CLK);
  endtask

  // Largest reference and divider, and the smallest realistic reference.
  task automatic test_large_ratio();
    wait_drained();
    apply_settings(27'h7FFFFFF, 27'd255, 27'd0, 27'd255, 27'd1);
    send_target(28'hFFFFFFF);
    wait_drained();
    apply_settings(27'd1000000, 27'd255, 27'd0, 27'd255, 27'd0);
    send_target(28'd250000000);
  endtask

  // Phases of random requests, each under a fresh register setting.
  task automatic test_random_phases();
    logic [26:0] fref, rdiv, fmin, fmax, odd;
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      odd = 27'($urandom_range(0, 1));
      case (p % 4)
        0: begin
          fref = 27'($urandom_range(1000000, 100000000));
          rdiv = 27'($urandom_range(1, 16));
          fmin = 27'($urandom_range(0, 64));
          fmax = 27'($urandom_range(128, 255));
        end
        1: begin
          // Raw register data, upper bits included.
          fref = 27'($urandom);
          rdiv = 27'($urandom);
          fmin = 27'($urandom);
          fmax = 27'($urandom);
          odd  = 27'($urandom);
        end
        2: begin
          case ($urandom_range(0, 3))
            0: fref = 27'd1000000;
            1: fref = 27'd100000000;
            2: fref = 27'h7FFFFFF;
            default: fref = 27'd14318180;
          endcase
          rdiv = $urandom_range(0, 1) ? 27'd1 : 27'd255;
          fmin = 27'($urandom_range(0, 1));
          fmax = 27'($urandom_range(254, 255));
        end
        default: begin
          // Narrow windows push the search deep into the table.
          fref = 27'($urandom_range(1000000, 100000000));
          rdiv = 27'($urandom_range(1, 8));
          fmin = 27'($urandom_range(20, 200));
          fmax = fmin + 27'($urandom_range(0, 30));
          if (fmax > 27'd255) fmax = 27'd255;
        end
      endcase
      apply_settings(fref, rdiv, fmin, fmax, odd);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_target(random_target());
      end
    end
  endtask

  // Receiver backpressure: the pattern is redrawn at random whenever its down counter runs out.
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= 200;
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cnt % 32) < 12;
    endcase
  end

  // Each result transfer is compared with the oldest expected setting.
  always @(posedge clk) begin
    pll_settings_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (settings_q.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(out_status), 64'd0);
      end else begin
        want = settings_q.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_post_div_value !== want.ratio)
          report_mismatch("post_div_value", 64'(out_post_div_value), 64'(want.ratio));
        if (out_post_div_code !== want.code)
          report_mismatch("post_div_code", 64'(out_post_div_code), 64'(want.code));
        if (out_feedback_div !== want.fb_div)
          report_mismatch("feedback_div", 64'(out_feedback_div), 64'(want.fb_div));
        if (out_achieved_freq !== want.freq)
          report_mismatch("achieved_freq", 64'(out_achieved_freq), 64'(want.freq));
      end
      result_count++;
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_odd_dividers();
    test_feedback_window();
    test_low_reference();
    test_zero_ref_divider();
    test_bad_index();
    test_large_ratio();
    test_random_phases();
    // Let the last request finish and watch for any stray result.
    wait_drained();
    repeat (500) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
